### hdl/altpg_pkg.sv
// Shared types and constants for the audio level tile pattern generator.
// Used by altpg_regs, altpg_shade and the top level. No dependencies.
package altpg_pkg;

  // Item kinds
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_TILE = 1'b1
  } op_t;

  // Register indexes on the configuration port (byte address / 4)
  typedef enum logic [1:0] {
    REG_ATTACK   = 2'd0,
    REG_RELEASE  = 2'd1,
    REG_DT_LIMIT = 2'd2
  } reg_idx_t;

  localparam int ADDR_W = 4;

  // Input beat
  typedef struct packed {
    op_t         operation;
    logic [15:0] dt_ms;
    logic [7:0]  target_level;
    logic        paused;
    logic [2:0]  tile_row;
    logic [3:0]  tile_col;
  } req_t;

  // Result beat
  typedef struct packed {
    logic [7:0]  level_now;
    logic [15:0] tile_colour;
  } rsp_t;

  // Configuration registers
  typedef struct packed {
    logic [9:0] attack_rate;
    logic [9:0] release_rate;
    logic [9:0] dt_limit;
  } cfg_t;

  // Unscaled wheel colour
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  localparam logic [9:0] ATTACK_RESET   = 10'd120;
  localparam logic [9:0] RELEASE_RESET  = 10'd35;
  localparam logic [9:0] DT_LIMIT_RESET = 10'd150;

  // floor(p/1000) = (p * RECIP_1000) >> 30, exact for p below 2^20
  localparam logic [20:0] RECIP_1000       = 21'd1073742;
  localparam int          RECIP_1000_SHIFT = 30;
  // floor(d/14) = (d * RECIP_14) >> 14, exact for d below 1024
  localparam logic [10:0] RECIP_14         = 11'd1171;
  localparam int          RECIP_14_SHIFT   = 14;

  localparam logic [5:0]  PHASE_DIV       = 6'd14;
  // 2^32 = 14*306783378 + 4: on counter wrap the remainder gains 10 and
  // the quotient loses 306783379, which is 147 mod 256
  localparam logic [5:0]  WRAP_REM_ADJ    = 6'd10;
  localparam logic [7:0]  WRAP_PHASE_ADJ  = 8'd147;

  localparam logic [7:0]  WHEEL_SECTION   = 8'd85;
  localparam logic [7:0]  PULSE_BASE      = 8'd30;
  localparam logic [6:0]  ENERGY_BASE     = 7'd35;
  localparam logic [6:0]  ENERGY_EDGE     = 7'd29;

endpackage

### hdl/audio_level_tile_pattern_generator.sv
// Registered path: input register, stage 1 to 3 registers, then the result register.
// Throughput: one item per cycle while rsp_ready keeps the output moving; the
// elapsed counter and level are read and updated in the third stage, so items never wait on one another.
// Reset (rst, synchronous): state, pipeline valids and config registers
// return to their reset values at once; no clearing pass.
module audio_level_tile_pattern_generator import altpg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  req_t              req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output rsp_t              rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef struct packed {
    op_t         op;
    logic [7:0]  target;
    logic        paused;
    logic [9:0]  dt;
    logic [6:0]  dq;
    logic [19:0] prod_a;
    logic [19:0] prod_r;
    logic [7:0]  pos;
    logic [6:0]  ebase;
  } s1_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  target;
    logic        paused;
    logic [9:0]  dt;
    logic [6:0]  dq;
    logic [3:0]  dr;
    logic [10:0] step_a;
    logic [10:0] step_r;
    logic [7:0]  pos;
    logic [6:0]  ebase;
  } s2_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] level;
    rgb_t       wheel;
    logic [7:0] energy;
  } s3_t;

  cfg_t cfg;

  altpg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // pipeline registers
  logic v0, v1, v2, v3;
  req_t r0;
  s1_t  s1, s1_next;
  s2_t  s2, s2_next;
  s3_t  s3, s3_next;

  // state
  logic [31:0] elapsed;
  logic [7:0]  ph_q;
  logic [3:0]  ph_r;
  logic [7:0]  level;

  // stage moves: a stage advances when the next one is empty or advancing
  logic mv1, mv2, mv3, mv4;
  assign mv4       = v3 && (!rsp_valid || rsp_ready);
  assign mv3       = v2 && (!v3 || mv4);
  assign mv2       = v1 && (!v2 || mv3);
  assign mv1       = v0 && (!v1 || mv2);
  assign req_ready = !v0 || mv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      v0        <= (req_valid && req_ready) || (v0 && !mv1);
      v1        <= mv1 || (v1 && !mv2);
      v2        <= mv2 || (v2 && !mv3);
      v3        <= mv3 || (v3 && !mv4);
      rsp_valid <= mv4 || (rsp_valid && !rsp_ready);
    end
  end

  // input register, loaded on each accepted beat
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) r0 <= req;
  end

  // stage 1: tick clamp, rate products, dt/14; tile position terms
  logic [9:0]  dt_c;
  logic [20:0] p14;
  logic [7:0]  col8, row8;
  logic [6:0]  centre;
  always_comb begin
    dt_c = (r0.dt_ms > {6'd0, cfg.dt_limit}) ? cfg.dt_limit : r0.dt_ms[9:0];
    p14  = 21'(dt_c) * 21'(RECIP_14);
    col8 = {4'd0, r0.tile_col};
    row8 = {5'd0, r0.tile_row};
    centre = (r0.tile_col <= 4'd7) ? 7'(r0.tile_col) : 7'(5'd14 - 5'(r0.tile_col));

    s1_next.op     = r0.operation;
    s1_next.target = r0.target_level;
    s1_next.paused = r0.paused;
    s1_next.dt     = dt_c;
    s1_next.dq     = p14[RECIP_14_SHIFT +: 7];
    s1_next.prod_a = 20'(dt_c) * 20'(cfg.attack_rate);
    s1_next.prod_r = 20'(dt_c) * 20'(cfg.release_rate);
    s1_next.pos    = 8'(8'd13 * col8 - 8'd17 * row8 + 8'd2 * col8 * row8);
    // column 15 sits one step outside the centre ramp
    if (r0.tile_col == 4'd15) begin
      s1_next.ebase = 7'(ENERGY_EDGE + 7'({row8[4:0], 2'b00}));
    end else begin
      s1_next.ebase = 7'(ENERGY_BASE + 7'(centre * 7'd6) + 7'({row8[4:0], 2'b00}));
    end
  end

  always_ff @(posedge clk) begin
    if (mv1) s1 <= s1_next;
  end

  // stage 2: steps per 1000 ms with the minimum of one, dt mod 14
  logic [40:0] qa, qr;
  logic [9:0]  dq14;
  logic [9:0]  dr10;
  always_comb begin
    qa   = 41'(s1.prod_a) * 41'(RECIP_1000);
    qr   = 41'(s1.prod_r) * 41'(RECIP_1000);
    dq14 = 10'(s1.dq) * 10'(PHASE_DIV);
    dr10 = s1.dt - dq14;

    s2_next.op     = s1.op;
    s2_next.target = s1.target;
    s2_next.paused = s1.paused;
    s2_next.dt     = s1.dt;
    s2_next.dq     = s1.dq;
    s2_next.dr     = dr10[3:0];
    s2_next.step_a = (qa[RECIP_1000_SHIFT +: 11] == 11'd0) ? 11'd1 : qa[RECIP_1000_SHIFT +: 11];
    s2_next.step_r = (qr[RECIP_1000_SHIFT +: 11] == 11'd0) ? 11'd1 : qr[RECIP_1000_SHIFT +: 11];
    s2_next.pos    = s1.pos;
    s2_next.ebase  = s1.ebase;
  end

  always_ff @(posedge clk) begin
    if (mv2) s2 <= s2_next;
  end

  // stage 3: state update for ticks, wheel colour for tiles
  logic [9:0]  dt_eff;
  logic [6:0]  dq_eff;
  logic [3:0]  dr_eff;
  logic [32:0] esum;
  logic [5:0]  rsum;
  logic [1:0]  qinc;
  logic [5:0]  rsub;
  logic [5:0]  rem6;
  logic [7:0]  ph_q_next;
  logic [11:0] up, down;
  logic [7:0]  lvl_tick;
  logic [7:0]  level_next;
  logic [7:0]  pulse, motion, sbase;
  logic [6:0]  diff;
  logic [7:0]  off;
  rgb_t        wheel;
  always_comb begin
    dt_eff = s2.paused ? 10'd0 : s2.dt;
    dq_eff = s2.paused ? 7'd0  : s2.dq;
    dr_eff = s2.paused ? 4'd0  : s2.dr;

    // elapsed counter with its running quotient and remainder by 14
    esum = {1'b0, elapsed} + 33'(dt_eff);
    rsum = 6'(ph_r) + 6'(dr_eff) + (esum[32] ? WRAP_REM_ADJ : 6'd0);
    if (rsum >= 6'(PHASE_DIV * 6'd2)) begin
      qinc = 2'd2;
      rsub = 6'(PHASE_DIV * 6'd2);
    end else if (rsum >= PHASE_DIV) begin
      qinc = 2'd1;
      rsub = PHASE_DIV;
    end else begin
      qinc = 2'd0;
      rsub = 6'd0;
    end
    rem6      = rsum - rsub;
    ph_q_next = ph_q + 8'(dq_eff) + 8'(qinc) - (esum[32] ? WRAP_PHASE_ADJ : 8'd0);

    // level follower, clamped at the target
    up   = 12'(level) + 12'(s2.step_a);
    down = (12'(level) > 12'(s2.step_r)) ? 12'(level) - 12'(s2.step_r) : 12'd0;
    if (level < s2.target) begin
      lvl_tick = (up > 12'(s2.target)) ? s2.target : up[7:0];
    end else if (level > s2.target) begin
      lvl_tick = (down < 12'(s2.target)) ? s2.target : down[7:0];
    end else begin
      lvl_tick = level;
    end
    level_next = (s2.op == OP_TICK) ? lvl_tick : level;

    // three-section wheel; the pulse wraps at 8 bits
    pulse  = 8'(PULSE_BASE + {level[6:0], 1'b0});
    motion = ph_q + s2.pos;
    // the last position opens a fourth section with a zero offset
    if (motion == 8'(WHEEL_SECTION * 8'd3)) begin
      sbase = 8'(WHEEL_SECTION * 8'd3);
    end else if (motion >= 8'(WHEEL_SECTION * 8'd2)) begin
      sbase = 8'(WHEEL_SECTION * 8'd2);
    end else if (motion >= WHEEL_SECTION) begin
      sbase = WHEEL_SECTION;
    end else begin
      sbase = 8'd0;
    end
    diff = 7'(motion - sbase);
    off  = 8'(diff) * 8'd3;
    if (sbase == 8'd0) begin
      wheel.r = 8'd255 - off;
      wheel.g = off;
      wheel.b = 8'd0;
    end else if (sbase == WHEEL_SECTION) begin
      wheel.r = 8'd0;
      wheel.g = 8'd255 - off;
      wheel.b = off;
    end else begin
      wheel.r = off;
      wheel.g = 8'd0;
      wheel.b = 8'd255 - off;
    end

    s3_next.op     = s2.op;
    s3_next.level  = level_next;
    s3_next.wheel  = wheel;
    s3_next.energy = 8'(s2.ebase) + 8'(pulse[7:1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0;
      ph_q    <= '0;
      ph_r    <= '0;
      level   <= '0;
    end else if (mv3 && s2.op == OP_TICK) begin
      elapsed <= esum[31:0];
      ph_q    <= ph_q_next;
      ph_r    <= rem6[3:0];
      level   <= lvl_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (mv3) s3 <= s3_next;
  end

  // stage 4: brightness scaling and packing into the result register
  logic [15:0] colour;

  altpg_shade u_shade (
    .wheel  (s3.wheel),
    .energy (s3.energy),
    .colour (colour)
  );

  always_ff @(posedge clk) begin
    if (mv4) begin
      rsp.level_now   <= s3.level;
      rsp.tile_colour <= (s3.op == OP_TILE) ? colour : 16'd0;
    end
  end

  // checks
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    ph_r < 4'd14)
    else $error("phase remainder out of range");

  a_tile_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (mv3 && s2.op == OP_TILE) |=>
      ($stable(elapsed) && $stable(level) && $stable(ph_q) && $stable(ph_r)))
    else $error("tile query changed state");

  a_attack_bounded: assert property (@(posedge clk) disable iff (rst)
    (mv3 && s2.op == OP_TICK && level < s2.target) |=>
      (level > $past(level) && level <= $past(s2.target)))
    else $error("attack step missed or overshot target");

  a_release_bounded: assert property (@(posedge clk) disable iff (rst)
    (mv3 && s2.op == OP_TICK && level > s2.target) |=>
      (level < $past(level) && level >= $past(s2.target)))
    else $error("release step missed or overshot target");

endmodule

### hdl/altpg_regs.sv
// APB-style configuration register file: attack/release rates and tick limit.
// Depends on altpg_pkg.
module altpg_regs import altpg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;

  // write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack_rate  <= ATTACK_RESET;
      cfg.release_rate <= RELEASE_RESET;
      cfg.dt_limit     <= DT_LIMIT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_ATTACK:   cfg.attack_rate  <= pwdata[9:0];
        REG_RELEASE:  cfg.release_rate <= pwdata[9:0];
        REG_DT_LIMIT: cfg.dt_limit     <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_ATTACK:   prdata = {22'd0, cfg.attack_rate};
      REG_RELEASE:  prdata = {22'd0, cfg.release_rate};
      REG_DT_LIMIT: prdata = {22'd0, cfg.dt_limit};
      default:      prdata = '0;
    endcase
  end

endmodule

### hdl/altpg_shade.sv
// Brightness scaling of a wheel colour and RGB565 packing.
// Depends on altpg_pkg.
module altpg_shade import altpg_pkg::*; (
  input  rgb_t        wheel,
  input  logic [7:0]  energy,
  output logic [15:0] colour
);

  // floor(x/255) for x up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'(x >> 8) + 17'd1;
    return t[15:8];
  endfunction

  logic [15:0] pr, pg, pb;
  logic [7:0]  sr, sg, sb;

  always_comb begin
    pr = 16'(wheel.r) * 16'(energy);
    pg = 16'(wheel.g) * 16'(energy);
    pb = 16'(wheel.b) * 16'(energy);
    sr = div255(pr);
    sg = div255(pg);
    sb = div255(pb);
    colour = {sr[7:3], sg[7:2], sb[7:3]};
  end

endmodule
